// File: sv/fdc765_pkg.sv
// Shared types and constants for the fdc765 floppy controller core.
// No dependencies; used by the core.
package fdc765_pkg;

	// access kinds
	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_READ   = 2'd1,
		KIND_WRITE  = 2'd2,
		KIND_LOAD   = 2'd3
	} kind_t;

	// register indexes
	localparam logic REG_DISK_PRESENT  = 1'b0;
	localparam logic REG_WRITE_PROTECT = 1'b1;

	// opcodes (low five bits of the first command byte)
	localparam logic [7:0] OP_READ_TRACK   = 8'd2;
	localparam logic [7:0] OP_SENSE_DRIVE  = 8'd4;
	localparam logic [7:0] OP_WRITE_DATA   = 8'd5;
	localparam logic [7:0] OP_READ_DATA    = 8'd6;
	localparam logic [7:0] OP_RECALIBRATE  = 8'd7;
	localparam logic [7:0] OP_SENSE_INT    = 8'd8;
	localparam logic [7:0] OP_READ_ID      = 8'd10;
	localparam logic [7:0] OP_SEEK         = 8'd15;

	// main status values and bits
	localparam logic [7:0] MS_IDLE     = 8'h80;
	localparam logic [7:0] MS_RESULT   = 8'hD0;
	localparam logic [7:0] MS_READ_X   = 8'hF0;
	localparam logic [7:0] MS_WRITE_X  = 8'hB0;
	localparam logic [7:0] MS_BUSY     = 8'h10;
	localparam logic [7:0] MS_EXEC     = 8'h20;

	// status byte values
	localparam logic [7:0] ST0_NOT_READY = 8'hD8;
	localparam logic [7:0] ST0_SEEK_END  = 8'h20;
	localparam logic [7:0] ST0_EQ_CHECK  = 8'h30;
	localparam logic [7:0] ST0_ABNORMAL  = 8'h40;
	localparam logic [7:0] ST1_END_CYL   = 8'h80;
	localparam logic [7:0] ID_SIZE_CODE  = 8'h41;
	localparam logic [7:0] RECAL_STEPS   = 8'd77;

	// bytes per command, by opcode
	function automatic logic [3:0] cmd_len(input logic [4:0] op);
		case (op)
			5'd2, 5'd5, 5'd6, 5'd9, 5'd12, 5'd17, 5'd25, 5'd30: cmd_len = 4'd9;
			5'd3, 5'd15: cmd_len = 4'd3;
			5'd4, 5'd7, 5'd10: cmd_len = 4'd2;
			5'd13: cmd_len = 4'd6;
			default: cmd_len = 4'd1;
		endcase
	endfunction

endpackage

// File: sv/fdc765_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module fdc765_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		if (re) rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule

// File: sv/floppy_controller_fdc765_core.sv
// Floppy controller core: each accepted request (status read, data read, data write or
// image load) gives one result, so requests may follow back to back at one per cycle
// while the output side does not stall. The disk image lives in a 1 MiB single-port RAM;
// a data read that streams image bytes picks its byte up from the RAM's registered read,
// in a stage ahead of the output register, so a request is accepted while a result waits.
// The image holds no defined data until it is loaded. No clearing pass after reset.
// Depends on fdc765_pkg and fdc765_ram.
module floppy_controller_fdc765_core #(
	parameter int DRIVES           = 4,
	parameter int TRACK_SLOTS      = 64,
	parameter int TRACK_BYTES      = 4096,
	parameter int HEADS            = 1,
	parameter int READ_TRACK_UNITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  image_drive,
	input  logic [17:0] image_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        command_flag,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int SPAN = TRACK_SLOTS * TRACK_BYTES;
	localparam int PW   = $clog2(SPAN);
	localparam logic [19:0] RT_LEN = 20'((READ_TRACK_UNITS << 9) & 32'hFFFFF);

	typedef logic [7:0]    trk_tab_t [256];
	typedef logic [PW-1:0] ss9_tab_t [16];
	typedef logic [PW-1:0] ss8_tab_t [32];

	function automatic trk_tab_t mk_trk();
		trk_tab_t t;
		for (int i = 0; i < 256; i++) t[i] = 8'(i % TRACK_SLOTS);
		return t;
	endfunction

	function automatic ss9_tab_t mk_ss9();
		ss9_tab_t t;
		for (int i = 0; i < 16; i++) t[i] = PW'((((i - 1) << 9) & 65535) % SPAN);
		return t;
	endfunction

	function automatic ss8_tab_t mk_ss8();
		ss8_tab_t t;
		for (int i = 0; i < 32; i++) t[i] = PW'((((i - 1) << 8) & 65535) % SPAN);
		return t;
	endfunction

	localparam trk_tab_t TRK_MOD = mk_trk();
	localparam ss9_tab_t SS9_MOD = mk_ss9();
	localparam ss8_tab_t SS8_MOD = mk_ss8();

	// image offset of a transfer start, already reduced into the image span
	function automatic logic [PW-1:0] base_ptr(input logic [7:0] trk, input logic sd,
			input logic [PW-1:0] ssm);
		logic [8:0]  slot;
		logic [PW:0] sum;
		slot = 9'(TRK_MOD[trk]) * 9'(HEADS) + 9'(sd);
		if (slot >= 9'(TRACK_SLOTS)) slot = slot - 9'(TRACK_SLOTS);
		sum = (PW+1)'(slot) * (PW+1)'(TRACK_BYTES) + (PW+1)'(ssm);
		if (sum >= (PW+1)'(SPAN)) sum = sum - (PW+1)'(SPAN);
		return sum[PW-1:0];
	endfunction

	function automatic logic has_disk(input logic [1:0] d, input logic [3:0] m);
		return (3'(d) < 3'(DRIVES)) && m[d];
	endfunction

	// config registers
	logic [3:0] disk_q, wp_q;

	// controller state
	logic [7:0]    cb_q [9];
	logic [3:0]    cidx_q;
	logic          exec_q, resph_q, flag_q;
	logic [7:0]    ms_q;
	logic [7:0]    st_q [4];
	logic [7:0]    rb_q [7];
	logic [2:0]    ridx_q, rcnt_q;
	logic [19:0]   didx_q, dlen_q;
	logic [1:0]    cd_q;
	logic [7:0]    trk_q [4];
	logic          side_q [4];
	logic [PW-1:0] ptr_q;

	logic [7:0]    n_cb [9];
	logic [3:0]    n_cidx;
	logic          n_exec, n_resph, n_flag;
	logic [7:0]    n_ms;
	logic [7:0]    n_st [4];
	logic [7:0]    n_rb [7];
	logic [2:0]    n_ridx, n_rcnt;
	logic [19:0]   n_didx, n_dlen;
	logic [1:0]    n_cd;
	logic [7:0]    n_trk [4];
	logic          n_side [4];
	logic [PW-1:0] n_ptr;

	logic        do_ex, do_seven, do_id;
	logic [7:0]  rd_c, s;
	logic        use_ram;
	logic        ram_we, ram_re;
	logic [19:0] ram_addr;
	logic [1:0]  d;
	logic [15:0] ss16;

	// pipeline and output registers
	logic       v_s1, ram_s1, flag_s1;
	logic [7:0] rd_s1;
	logic       out_v_q, out_flag_q;
	logic [7:0] out_rd_q;
	logic [7:0] ram_q;
	logic       accept, move;

	assign move     = v_s1 && (!out_v_q || !out_stall);
	assign in_stall = v_s1 && out_v_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// request decode and state update
	always_comb begin
		n_cb = cb_q; n_cidx = cidx_q; n_exec = exec_q; n_resph = resph_q; n_flag = flag_q;
		n_ms = ms_q; n_st = st_q; n_rb = rb_q; n_ridx = ridx_q; n_rcnt = rcnt_q;
		n_didx = didx_q; n_dlen = dlen_q; n_cd = cd_q; n_trk = trk_q; n_side = side_q;
		n_ptr = ptr_q;
		do_ex = 1'b0; do_seven = 1'b0; do_id = 1'b0;
		rd_c = 8'h00; use_ram = 1'b0; ram_we = 1'b0; ram_re = 1'b0;
		ram_addr = {cd_q, 18'(ptr_q)};
		s = 8'h00; d = 2'd0; ss16 = 16'h0000;
		case (fdc765_pkg::kind_t'(kind))
			fdc765_pkg::KIND_STATUS: rd_c = ms_q;
			fdc765_pkg::KIND_READ: begin
				n_flag = 1'b0;
				if (exec_q) begin
					if (cb_q[0] == fdc765_pkg::OP_READ_TRACK ||
							cb_q[0] == fdc765_pkg::OP_READ_DATA) begin
						use_ram = 1'b1;
						ram_re = 1'b1;
						n_didx = didx_q + 20'd1;
						n_ptr = (ptr_q == PW'(SPAN - 1)) ? '0 : ptr_q + PW'(1);
						if (n_didx == dlen_q) begin
							n_st[0] = (cb_q[1] & 8'h07) | fdc765_pkg::ST0_ABNORMAL;
							n_st[1] = fdc765_pkg::ST1_END_CYL;
							do_seven = 1'b1;
						end
					end
				end else if (resph_q) begin
					rd_c = (ridx_q < 3'd7) ? rb_q[ridx_q] : 8'h00;
					n_ridx = ridx_q + 3'd1;
					if (n_ridx == rcnt_q) begin
						n_ms = fdc765_pkg::MS_IDLE;
						n_resph = 1'b0;
					end
				end
			end
			fdc765_pkg::KIND_WRITE: begin
				if (exec_q) begin
					do_ex = 1'b1;
				end else begin
					if (cidx_q == 4'd0) begin
						n_cb[0] = data_byte & 8'h1F;
						n_cidx = 4'd1;
						n_ms = ms_q | fdc765_pkg::MS_BUSY;
					end else if (cidx_q < fdc765_pkg::cmd_len(cb_q[0][4:0])) begin
						n_cb[cidx_q] = data_byte;
						n_cidx = cidx_q + 4'd1;
					end
					if (n_cidx == fdc765_pkg::cmd_len(n_cb[0][4:0])) begin
						n_cidx = 4'd0;
						n_ms = n_ms | fdc765_pkg::MS_EXEC;
						n_flag = 1'b1;
						do_ex = 1'b1;
					end
				end
			end
			default: begin
				ram_we = 1'b1;
				ram_addr = {image_drive, image_offset};
			end
		endcase

		// command execution
		if (do_ex) begin
			case (n_cb[0])
				fdc765_pkg::OP_READ_TRACK: begin
					n_cd = n_cb[1][1:0];
					n_side[n_cd] = n_cb[1][2];
					n_trk[n_cd] = n_cb[2];
					if (!has_disk(n_cd, disk_q)) begin
						n_st[0] = {6'b0, n_cd} | fdc765_pkg::ST0_NOT_READY;
						do_seven = 1'b1;
					end else begin
						n_dlen = RT_LEN;
						n_exec = 1'b1;
						n_ptr = base_ptr(n_trk[n_cd], n_side[n_cd], SS9_MOD[n_cb[4][3:0]]);
						n_didx = 20'd0;
						n_ms = fdc765_pkg::MS_READ_X;
					end
				end
				fdc765_pkg::OP_SENSE_DRIVE: begin
					n_cd = n_cb[1][1:0];
					s = n_cb[1] & 8'h07;
					if ((3'(n_cd) < 3'(DRIVES)) && wp_q[n_cd]) s = s | 8'h40;
					if (has_disk(n_cd, disk_q)) s = s | 8'h20;
					if (n_trk[n_cd] == 8'd0) s = s | 8'h10;
					if (s[2]) s = s | 8'h08;
					n_st[3] = s;
					n_rb[0] = s;
					n_rcnt = 3'd1;
					n_ridx = 3'd0;
					n_exec = 1'b0;
					n_resph = 1'b1;
					n_ms = fdc765_pkg::MS_RESULT;
				end
				fdc765_pkg::OP_WRITE_DATA: begin
					if (!exec_q) begin
						n_cd = n_cb[1][1:0];
						n_side[n_cd] = n_cb[1][2];
						n_trk[n_cd] = n_cb[2];
						n_exec = 1'b1;
						if (!has_disk(n_cd, disk_q)) begin
							n_st[0] = {6'b0, n_cd} | fdc765_pkg::ST0_NOT_READY;
							do_seven = 1'b1;
						end else begin
							n_dlen = 20'd512 + ((20'(n_cb[4]) - 20'(n_cb[6])) << 9);
							n_ptr = base_ptr(n_trk[n_cd], n_side[n_cd],
								SS9_MOD[n_cb[4][3:0]]);
							n_didx = 20'd0;
							n_ms = fdc765_pkg::MS_WRITE_X;
						end
					end else begin
						ram_we = 1'b1;
						n_didx = didx_q + 20'd1;
						n_ptr = (ptr_q == PW'(SPAN - 1)) ? '0 : ptr_q + PW'(1);
						if (n_didx == dlen_q) begin
							n_st[0] = n_cb[1] & 8'h07;
							do_seven = 1'b1;
						end
					end
				end
				fdc765_pkg::OP_READ_DATA: begin
					n_cd = n_cb[1][1:0];
					n_side[n_cd] = n_cb[1][2];
					n_trk[n_cd] = n_cb[2];
					if (!has_disk(n_cd, disk_q)) begin
						n_st[0] = {6'b0, n_cd} | fdc765_pkg::ST0_NOT_READY;
						do_seven = 1'b1;
					end else begin
						ss16 = 16'((16'(n_cb[4][4:0]) - 16'd1) << 8);
						n_dlen = 20'(ss16) + 20'd256;
						n_exec = 1'b1;
						n_ptr = base_ptr(n_trk[n_cd], n_side[n_cd], SS8_MOD[n_cb[4][4:0]]);
						n_didx = 20'd0;
						n_ms = fdc765_pkg::MS_READ_X;
					end
				end
				fdc765_pkg::OP_RECALIBRATE: begin
					n_st[1] = 8'h00;
					n_st[2] = 8'h00;
					d = n_cb[1][1:0];
					n_cd = d;
					s = n_cb[1] & 8'h07;
					if (!has_disk(d, disk_q)) begin
						s = s | fdc765_pkg::ST0_NOT_READY;
					end else if (n_trk[d] > fdc765_pkg::RECAL_STEPS) begin
						n_trk[d] = n_trk[d] - fdc765_pkg::RECAL_STEPS;
						s = s | fdc765_pkg::ST0_EQ_CHECK;
					end else begin
						n_trk[d] = 8'd0;
						s = s | fdc765_pkg::ST0_SEEK_END;
					end
					n_st[0] = s;
					n_ms = fdc765_pkg::MS_IDLE | (8'd1 << d);
					n_exec = 1'b0;
				end
				fdc765_pkg::OP_SENSE_INT: begin
					n_ms = fdc765_pkg::MS_RESULT;
					n_rcnt = 3'd2;
					n_ridx = 3'd0;
					s = n_st[0];
					if (!has_disk(n_cd, disk_q)) s = s | 8'h08;
					n_rb[0] = s & 8'h3F;
					n_st[0] = 8'h00;
					n_rb[1] = n_trk[n_cd];
					n_exec = 1'b0;
					n_resph = 1'b1;
				end
				fdc765_pkg::OP_READ_ID: begin
					n_cd = n_cb[1][1:0];
					n_side[n_cd] = n_cb[1][2];
					if (!has_disk(n_cd, disk_q)) begin
						n_st[0] = {6'b0, n_cd} | fdc765_pkg::ST0_NOT_READY;
					end else begin
						n_st[0] = n_cb[1] & 8'h07;
						do_id = 1'b1;
					end
					do_seven = 1'b1;
				end
				fdc765_pkg::OP_SEEK: begin
					d = n_cb[1][1:0];
					n_ms = fdc765_pkg::MS_IDLE | (8'd1 << d);
					n_cd = d;
					n_side[d] = n_cb[1][2];
					if (!has_disk(d, disk_q)) begin
						n_st[0] = {6'b0, d} | fdc765_pkg::ST0_NOT_READY;
						do_seven = 1'b1;
					end else begin
						n_trk[d] = n_cb[2];
						n_st[0] = fdc765_pkg::ST0_SEEK_END | (n_cb[1] & 8'h07);
						n_exec = 1'b0;
					end
				end
				default: ;
			endcase
		end

		// seven-byte result phase
		if (do_seven) begin
			n_rb[0] = n_st[0];
			n_rb[1] = n_st[1];
			n_rb[2] = n_st[2];
			n_rb[3] = n_cb[2];
			n_rb[4] = n_cb[3];
			n_rb[5] = do_id ? fdc765_pkg::ID_SIZE_CODE : n_cb[4];
			n_rb[6] = n_cb[5];
			n_ms = fdc765_pkg::MS_RESULT;
			n_ridx = 3'd0;
			n_rcnt = 3'd7;
			n_st[0] = 8'h00;
			n_st[1] = 8'h00;
			n_st[2] = 8'h00;
			n_exec = 1'b0;
			n_resph = 1'b1;
		end
	end

	// image store
	fdc765_ram #(.WIDTH(8), .DEPTH(1 << 20)) u_image (
		.clk   (clk),
		.we    (accept && ram_we),
		.re    (accept && ram_re),
		.addr  (ram_addr),
		.wdata (data_byte),
		.rdata (ram_q)
	);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) cb_q[i] <= 8'h00;
			for (int i = 0; i < 4; i++) begin
				st_q[i] <= 8'h00;
				trk_q[i] <= 8'h00;
				side_q[i] <= 1'b0;
			end
			for (int i = 0; i < 7; i++) rb_q[i] <= 8'h00;
			cidx_q <= 4'd0; exec_q <= 1'b0; resph_q <= 1'b0; flag_q <= 1'b0;
			ms_q <= fdc765_pkg::MS_IDLE; ridx_q <= 3'd0; rcnt_q <= 3'd0;
			didx_q <= 20'd0; dlen_q <= 20'd0; cd_q <= 2'd0; ptr_q <= '0;
		end else if (accept) begin
			cb_q <= n_cb; st_q <= n_st; trk_q <= n_trk; side_q <= n_side; rb_q <= n_rb;
			cidx_q <= n_cidx; exec_q <= n_exec; resph_q <= n_resph; flag_q <= n_flag;
			ms_q <= n_ms; ridx_q <= n_ridx; rcnt_q <= n_rcnt;
			didx_q <= n_didx; dlen_q <= n_dlen; cd_q <= n_cd; ptr_q <= n_ptr;
		end
	end

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q <= 4'h0;
			wp_q <= 4'h0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == fdc765_pkg::REG_DISK_PRESENT) disk_q <= pwdata[3:0];
			else wp_q <= pwdata[3:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = {28'h0, (paddr[2] == fdc765_pkg::REG_DISK_PRESENT) ? disk_q : wp_q};

	// RAM stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= rd_c;
			ram_s1 <= use_ram;
			flag_s1 <= n_flag;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_rd_q <= ram_s1 ? ram_q : rd_s1;
			out_flag_q <= flag_s1;
		end
	end

	assign out_valid    = out_v_q;
	assign read_data    = out_rd_q;
	assign command_flag = out_flag_q;
endmodule

// File: sv/fdc765_checker.sv
// Port-level checks for the fdc765 core, bound to the top level.
// Depends on floppy_controller_fdc765_core.
module fdc765_core_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  read_data,
	input logic        command_flag,
	input logic        psel,
	input logic        pwrite,
	input logic [31:0] prdata
);
	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its bytes
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(read_data) && $stable(command_flag))
		else $error("stalled result changed");

	// requests are held back only by a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stall without output backpressure");

	// mask registers read back four bits only
	a_prdata: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite |-> prdata[31:4] == 28'h0)
		else $error("register readback has stray bits");

	// no stall in the first cycle out of reset
	a_reset_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_stall)
		else $error("stall right after reset");
endmodule

bind floppy_controller_fdc765_core fdc765_core_checker u_fdc765_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.read_data    (read_data),
	.command_flag (command_flag),
	.psel         (psel),
	.pwrite       (pwrite),
	.prdata       (prdata)
);
